### rtl/byte_translate_delete_squeeze_assert.svh
// Assertion helpers used by the checker of this block.
// Each macro takes a label, a condition, a consequence and a message string.
// The checker that uses them provides clk_i and rst_ni.
`ifndef BYTE_TRANSLATE_DELETE_SQUEEZE_ASSERT_SVH
`define BYTE_TRANSLATE_DELETE_SQUEEZE_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define BTDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the condition.
`define BTDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/btds_pkg.sv
package btds_pkg;

  // Table geometry.
  localparam int SYMBOL_COUNT = 256;
  localparam int IDX_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int SYM_W        = 8;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // Queue between the lookup front and the squeeze back end.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_DATA = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELETE_EN  = CFG_IDX_W'(0),
    CFG_SQUEEZE_EN = CFG_IDX_W'(1)
  } cfg_idx_e;

  typedef struct packed {
    logic delete_en;
    logic squeeze_en;
  } cfg_t;

  // One translated byte on its way to the squeeze stage.
  typedef struct packed {
    logic [SYM_W-1:0] mapped;
    logic             squeeze_mark;
  } lane_t;

  // True when a byte value has an entry in the tables.
  function automatic logic sym_in_range(logic [SYM_W-1:0] s);
    return 32'(s) < 32'(SYMBOL_COUNT);
  endfunction

  // Table address of a byte value.
  function automatic logic [IDX_W-1:0] sym_index(logic [SYM_W-1:0] s);
    return IDX_W'(s);
  endfunction

endpackage

### rtl/btds_if.sv
// Input item channel: table loads and data bytes.
interface btds_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [btds_pkg::SYM_W-1:0] symbol;
  logic [btds_pkg::SYM_W-1:0] map_to;
  logic                       delete_mark;
  logic                       squeeze_mark;

  modport source (
    output valid, mode, symbol, map_to, delete_mark, squeeze_mark,
    input  ready
  );
  modport sink (
    input  valid, mode, symbol, map_to, delete_mark, squeeze_mark,
    output ready
  );
endinterface

// Result item channel: filtered bytes.
interface btds_out_if;
  logic                       valid;
  logic                       ready;
  logic [btds_pkg::SYM_W-1:0] out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink (input valid, out_byte, output ready);
endinterface

// Configuration write channel.
interface btds_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [btds_pkg::CFG_IDX_W-1:0]  index;
  logic [btds_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/btds_fifo.sv
module btds_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  btds_pkg::lane_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output btds_pkg::lane_t pop_item_o
);

  btds_pkg::lane_t                    slots_q [btds_pkg::FIFO_DEPTH];
  logic [btds_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [btds_pkg::FIFO_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [btds_pkg::FIFO_CNT_W-1:0]    count_q, count_d;
  logic                               push, pop;

  assign push_ready_o = count_q != btds_pkg::FIFO_CNT_W'(btds_pkg::FIFO_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == btds_pkg::FIFO_PTR_W'(btds_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == btds_pkg::FIFO_PTR_W'(btds_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### rtl/btds_front.sv
module btds_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  btds_in_if.sink         in_i,
  input  btds_pkg::cfg_t  cfg_i,
  output logic            lane_valid_o,
  input  logic            lane_ready_i,
  output btds_pkg::lane_t lane_o
);

  // Table memories; an entry that was never loaded reads as its reset value.
  logic [btds_pkg::SYM_W-1:0]        map_mem_q [btds_pkg::SYMBOL_COUNT];
  logic                              del_mem_q [btds_pkg::SYMBOL_COUNT];
  logic                              sq_mem_q  [btds_pkg::SYMBOL_COUNT];
  logic [btds_pkg::SYMBOL_COUNT-1:0] entry_vld_q;

  logic                        in_fire, is_load, in_ok, wr_en, rd_en;
  logic [btds_pkg::IDX_W-1:0]  in_idx, b_idx;

  // Lookup stage registers.
  logic                        a_vld_q, a_vld_d;
  logic [btds_pkg::SYM_W-1:0]  a_sym_q, a_map_q, a_mapped;
  logic                        a_del_q, a_hit_q;
  logic                        a_drop, a_adv, b_take, b_load;

  // Squeeze mark stage registers.
  logic                        b_vld_q, b_vld_d;
  logic [btds_pkg::SYM_W-1:0]  b_mapped_q;
  logic                        b_sq_q, b_hit_q;

  assign in_fire = in_i.valid && in_i.ready;
  assign is_load = in_i.mode == btds_pkg::MODE_LOAD;
  assign in_idx  = btds_pkg::sym_index(in_i.symbol);
  assign in_ok   = btds_pkg::sym_in_range(in_i.symbol);
  assign wr_en   = in_fire && is_load && in_ok;
  assign rd_en   = in_fire && !is_load;

  // A new item enters only when the lookup stage is empty or moves on in the
  // same cycle; no load overtakes the squeeze mark read of an earlier byte.
  assign a_mapped   = a_hit_q ? a_map_q : a_sym_q;
  assign a_drop     = cfg_i.delete_en && a_hit_q && a_del_q;
  assign b_take     = !b_vld_q || lane_ready_i;
  assign a_adv      = a_vld_q && (a_drop || b_take);
  assign b_load     = a_adv && !a_drop;
  assign b_idx      = btds_pkg::sym_index(a_mapped);
  assign in_i.ready = !a_vld_q || a_adv;

  assign lane_valid_o        = b_vld_q;
  assign lane_o.mapped       = b_mapped_q;
  assign lane_o.squeeze_mark = b_hit_q && b_sq_q;

  // Stage occupancy.
  always_comb begin
    a_vld_d = a_vld_q;
    if (rd_en) begin
      a_vld_d = 1'b1;
    end else if (a_adv) begin
      a_vld_d = 1'b0;
    end
    b_vld_d = b_vld_q;
    if (b_load) begin
      b_vld_d = 1'b1;
    end else if (lane_ready_i) begin
      b_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      entry_vld_q <= '0;
    end else begin
      a_vld_q <= a_vld_d;
      b_vld_q <= b_vld_d;
      if (wr_en) begin
        entry_vld_q[in_idx] <= 1'b1;
      end
    end
  end

  // Translation and delete tables, read by the source byte.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem_q[in_idx] <= in_i.map_to;
      del_mem_q[in_idx] <= in_i.delete_mark;
    end
    if (rd_en) begin
      a_map_q <= map_mem_q[in_idx];
      a_del_q <= del_mem_q[in_idx];
      a_sym_q <= in_i.symbol;
      a_hit_q <= in_ok && entry_vld_q[in_idx];
    end
  end

  // Squeeze table, read by the translated byte.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sq_mem_q[in_idx] <= in_i.squeeze_mark;
    end
    if (b_load) begin
      b_sq_q     <= sq_mem_q[b_idx];
      b_mapped_q <= a_mapped;
      b_hit_q    <= btds_pkg::sym_in_range(a_mapped) && entry_vld_q[b_idx];
    end
  end

endmodule

### rtl/btds_back.sv
module btds_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  btds_pkg::cfg_t  cfg_i,
  input  logic            lane_valid_i,
  output logic            lane_ready_o,
  input  btds_pkg::lane_t lane_i,
  btds_out_if.source      out_o
);

  logic                       out_vld_q, out_vld_d;
  logic [btds_pkg::SYM_W-1:0] out_byte_q;
  logic [btds_pkg::SYM_W-1:0] last_q;
  logic                       have_last_q;
  logic                       pop, squeeze_hit, emit;

  assign lane_ready_o = !out_vld_q || out_o.ready;
  assign pop          = lane_valid_i && lane_ready_o;

  // Squeeze on: a marked repeat of the last emitted byte drops.
  assign squeeze_hit = cfg_i.squeeze_en && have_last_q &&
                       (last_q == lane_i.mapped) && lane_i.squeeze_mark;
  assign emit        = pop && !squeeze_hit;

  assign out_o.valid    = out_vld_q;
  assign out_o.out_byte = out_byte_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      last_q      <= '0;
      have_last_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (emit) begin
        last_q      <= lane_i.mapped;
        have_last_q <= 1'b1;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= lane_i.mapped;
    end
  end

endmodule

### rtl/byte_translate_delete_squeeze.sv
// Byte filter in the style of tr: translate, delete and squeeze.
// Channels: in_i carries items; mode 0 loads one entry of the translation,
// delete and squeeze tables at index symbol, mode 1 is a data byte. out_o
// carries the surviving translated bytes. cfg_i writes delete_enable
// (index 0) and squeeze_enable (index 1) from bit 0 of data, and is always
// ready; writes to other indexes are ignored.
// Path: a data byte passes the lookup, squeeze mark read, queue and output
// register stages on its way to out_o. Loads take effect for the next item.
// Throughput: one item per cycle, loads and data bytes alike, while out_o
// is not stalled; the table read ports and the one-byte compare with the
// last emitted byte each sit in their own stage.
// Reset: the translation table is the identity, both mark tables are clear,
// no last byte is held and both enables are off. Per-entry valid bits make
// this instant; there is no clearing pass.
// Stall: when out_o is not ready the output register holds its item, the
// two-entry queue fills, then the squeeze mark and lookup stages fill, and
// in_i drops ready. No item is lost or repeated.
module byte_translate_delete_squeeze (
  input  logic       clk_i,
  input  logic       rst_ni,
  btds_in_if.sink    in_i,
  btds_out_if.source out_o,
  btds_cfg_if.sink   cfg_i
);

  btds_pkg::cfg_t  cfg_q;
  logic            f_lane_valid, f_lane_ready;
  btds_pkg::lane_t f_lane;
  logic            q_lane_valid, q_lane_ready;
  btds_pkg::lane_t q_lane;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        btds_pkg::CFG_DELETE_EN: begin
          cfg_q.delete_en <= cfg_i.data[0];
        end
        btds_pkg::CFG_SQUEEZE_EN: begin
          cfg_q.squeeze_en <= cfg_i.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Lookup front: table loads, translation and delete decision.
  btds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .lane_valid_o (f_lane_valid),
    .lane_ready_i (f_lane_ready),
    .lane_o       (f_lane)
  );

  btds_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_lane_valid),
    .push_ready_o (f_lane_ready),
    .push_item_i  (f_lane),
    .pop_valid_o  (q_lane_valid),
    .pop_ready_i  (q_lane_ready),
    .pop_item_o   (q_lane)
  );

  // Squeeze back end and output register.
  btds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .lane_valid_i (q_lane_valid),
    .lane_ready_o (q_lane_ready),
    .lane_i       (q_lane),
    .out_o        (out_o)
  );

endmodule

### rtl/btds_checker.sv
`include "byte_translate_delete_squeeze_assert.svh"

module btds_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_mode_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [btds_pkg::SYM_W-1:0] out_byte_i
);

  logic        data_fire, out_fire;
  logic [31:0] pend_q;

  assign data_fire = in_valid_i && in_ready_i && (in_mode_i == btds_pkg::MODE_DATA);
  assign out_fire  = out_valid_i && out_ready_i;

  // Data items accepted and not yet matched by a result item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (data_fire && !out_fire) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_fire && !data_fire) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // A stalled result item stays put.
  `BTDS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(out_byte_i), "stalled result item changed")

  // Every result item comes from an earlier data item.
  `BTDS_ASSERT_NOW(a_out_has_source, out_fire, pend_q != '0,
                   "result item without a data item")

  // The pipeline is empty right after reset.
  `BTDS_ASSERT_NOW(a_out_idle_after_reset, !$past(rst_ni), !out_valid_i,
                   "result item right after reset")

endmodule

bind byte_translate_delete_squeeze btds_checker u_btds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte)
);

### tb/sv/byte_translate_delete_squeeze_test.sv
`timescale 1ns / 100ps

module byte_translate_delete_squeeze_test;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_LIMIT = 50;
  localparam int          DRAIN_CYCLES = 8;

  // One item on the input channel, as the sender sees it.
  typedef struct packed {
    btds_pkg::mode_e            mode;
    logic [btds_pkg::SYM_W-1:0] symbol;
    logic [btds_pkg::SYM_W-1:0] map_to;
    logic                       delete_mark;
    logic                       squeeze_mark;
  } filter_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  btds_in_if  in_bus ();
  btds_out_if out_bus ();
  btds_cfg_if cfg_bus ();

  // Testbench-owned copies of every block input, known from time zero.
  logic                            drv_valid = 1'b0;
  filter_item_t                    drv_item  = '0;
  logic                            res_ready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [btds_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [btds_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  assign in_bus.valid        = drv_valid;
  assign in_bus.mode         = drv_item.mode;
  assign in_bus.symbol       = drv_item.symbol;
  assign in_bus.map_to       = drv_item.map_to;
  assign in_bus.delete_mark  = drv_item.delete_mark;
  assign in_bus.squeeze_mark = drv_item.squeeze_mark;
  assign out_bus.ready       = res_ready;
  assign cfg_bus.valid       = cfg_valid;
  assign cfg_bus.index       = cfg_index;
  assign cfg_bus.data        = cfg_data;

  byte_translate_delete_squeeze i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the filter tables, the last emitted byte and the enables.
  logic [btds_pkg::SYM_W-1:0] xlat_table  [256];
  logic                       drop_set    [256];
  logic                       squeeze_set [256];
  logic [btds_pkg::SYM_W-1:0] last_byte  = '0;
  logic                       last_valid = 1'b0;
  logic                       del_en     = 1'b0;
  logic                       sq_en      = 1'b0;

  filter_item_t               pending_items  [$];
  logic [btds_pkg::SYM_W-1:0] expected_bytes [$];

  int unsigned cycle_count = 0;
  int unsigned err_count   = 0;
  logic        hold_sender = 1'b0;

  // Sender burst shaping and receiver stall pattern.
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned ready_style = 0;
  int unsigned style_left  = 0;

  task automatic report_mismatch(string what);
    err_count++;
    if (err_count <= PRINT_LIMIT) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Apply one accepted item to the shadow state and queue the byte it emits.
  function automatic void filter_predict(filter_item_t it);
    logic [btds_pkg::SYM_W-1:0] mapped;
    logic                       in_tab;
    logic                       mapped_in_tab;
    in_tab = int'(it.symbol) < btds_pkg::SYMBOL_COUNT;
    if (it.mode == btds_pkg::MODE_LOAD) begin
      if (in_tab) begin
        xlat_table[it.symbol]  = it.map_to;
        drop_set[it.symbol]    = it.delete_mark;
        squeeze_set[it.symbol] = it.squeeze_mark;
      end
    end else if (!(del_en && in_tab && drop_set[it.symbol])) begin
      mapped        = in_tab ? xlat_table[it.symbol] : it.symbol;
      mapped_in_tab = int'(mapped) < btds_pkg::SYMBOL_COUNT;
      // A repeat of the last emitted byte is dropped only if it is squeeze-marked.
      if (!(sq_en && last_valid && last_byte == mapped && mapped_in_tab &&
            squeeze_set[mapped])) begin
        last_byte  = mapped;
        last_valid = 1'b1;
        expected_bytes.insert(expected_bytes.size(), mapped);
      end
    end
  endfunction

  // Sender: takes items from the pending queue in bursts with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_bus.ready) begin
        filter_predict(drv_item);
      end
      if (!drv_valid || in_bus.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (!hold_sender && pending_items.size() != 0) begin
          drv_item  <= pending_items.pop_front();
          drv_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 5) == 0) begin
            // A long stretch with no idling.
            burst_left = $urandom_range(40, 120);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result item and stalls on a pattern that changes style.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (out_bus.valid && res_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected out_byte 0x%02h", out_bus.out_byte));
        end else if (out_bus.out_byte !== expected_bytes[0]) begin
          report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                    out_bus.out_byte, expected_bytes.pop_front()));
        end else begin
          void'(expected_bytes.pop_front());
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        case (ready_style)
          0: begin
            res_ready <= 1'b1;
          end
          1: begin
            res_ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            res_ready <= 1'b1;
            if ($urandom_range(0, 15) == 0) begin
              stall_left = $urandom_range(1, 12);
            end
          end
        endcase
      end
      if (style_left != 0) begin
        style_left--;
      end else begin
        ready_style = $urandom_range(0, 2);
        style_left  = $urandom_range(50, 300);
      end
    end
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL byte_translate_delete_squeeze");
      $finish;
    end
  end

  // Wait until every item is sent and every result has come, then let the
  // pipeline drain bytes that were dropped.
  task automatic wait_idle();
    while (pending_items.size() != 0 || drv_valid || expected_bytes.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [btds_pkg::CFG_IDX_W-1:0] idx,
                           logic [btds_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    // Only bit 0 counts; other indexes are ignored.
    if (idx == btds_pkg::CFG_DELETE_EN) begin
      del_en = val[0];
    end else if (idx == btds_pkg::CFG_SQUEEZE_EN) begin
      sq_en = val[0];
    end
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic push_load(logic [btds_pkg::SYM_W-1:0] sym,
                           logic [btds_pkg::SYM_W-1:0] target,
                           logic del_mark, logic sq_mark);
    filter_item_t it;
    it.mode         = btds_pkg::MODE_LOAD;
    it.symbol       = sym;
    it.map_to       = target;
    it.delete_mark  = del_mark;
    it.squeeze_mark = sq_mark;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_data(logic [btds_pkg::SYM_W-1:0] sym);
    filter_item_t it;
    it.mode         = btds_pkg::MODE_DATA;
    it.symbol       = sym;
    it.map_to       = 8'($urandom);
    it.delete_mark  = 1'($urandom);
    it.squeeze_mark = 1'($urandom);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Stimulus sequence.
  initial begin
    filter_item_t               it;
    logic [btds_pkg::SYM_W-1:0] alpha [6];
    logic [btds_pkg::SYM_W-1:0] prev_sym;
    logic                       want_del;
    logic                       want_sq;
    prev_sym = '0;
    for (int i = 0; i < 256; i++) begin
      xlat_table[i]  = 8'(i);
      drop_set[i]    = 1'b0;
      squeeze_set[i] = 1'b0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Squeeze on before anything is emitted: the first zero byte must pass
    // although it equals the reset value of the last byte.
    write_reg(btds_pkg::CFG_SQUEEZE_EN, 8'h01);
    push_load(8'h00, 8'h00, 1'b0, 1'b1);
    push_data(8'h00);
    push_data(8'h00);
    push_data(8'hFF);
    wait_idle();

    // Both enables off: marks are loaded but have no effect.
    write_reg(btds_pkg::CFG_SQUEEZE_EN, 8'hFE);
    write_reg(btds_pkg::CFG_DELETE_EN, 8'h00);
    push_load(8'h41, 8'h61, 1'b0, 1'b1);
    push_load(8'h61, 8'h61, 1'b0, 1'b1);
    push_load(8'hFF, 8'h00, 1'b1, 1'b0);
    push_load(8'h00, 8'hFF, 1'b1, 1'b1);
    push_data(8'h41);
    push_data(8'h41);
    push_data(8'hFF);
    push_data(8'h00);
    wait_idle();

    // Both enables on, upper data bits set, and a write to an unused index.
    write_reg(btds_pkg::CFG_DELETE_EN, 8'h01);
    write_reg(btds_pkg::CFG_SQUEEZE_EN, 8'h03);
    write_reg(btds_pkg::CFG_IDX_W'(15), 8'hFF);
    push_data(8'h41);
    push_data(8'h41);
    push_data(8'h61);
    push_data(8'hFF);
    push_data(8'h41);
    push_data(8'h00);
    push_data(8'h00);
    push_load(8'h7F, 8'h7F, 1'b0, 1'b1);
    push_data(8'h7F);
    push_data(8'h7F);
    push_data(8'h80);

    // Random phases, each with its own enables and a small byte alphabet so
    // that repeats and squeezes are frequent.
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: begin want_del = 1'b0; want_sq = 1'b1; end
        1: begin want_del = 1'b1; want_sq = 1'b0; end
        2: begin want_del = 1'b1; want_sq = 1'b1; end
        3: begin want_del = 1'b0; want_sq = 1'b0; end
        default: begin want_del = 1'($urandom); want_sq = 1'($urandom); end
      endcase
      write_reg(btds_pkg::CFG_DELETE_EN, {7'($urandom), want_del});
      write_reg(btds_pkg::CFG_SQUEEZE_EN, {7'($urandom), want_sq});
      if ($urandom_range(0, 1) == 0) begin
        write_reg(btds_pkg::CFG_IDX_W'($urandom_range(2, 15)), 8'($urandom));
      end
      for (int k = 0; k < 6; k++) begin
        alpha[k] = 8'($urandom);
      end

      repeat (142) begin
        if ($urandom_range(0, 4) == 0) begin
          it.mode         = btds_pkg::MODE_LOAD;
          it.symbol       = ($urandom_range(0, 4) != 0) ? alpha[$urandom_range(0, 5)]
                                                        : 8'($urandom);
          it.map_to       = ($urandom_range(0, 2) != 0) ? alpha[$urandom_range(0, 5)]
                                                        : 8'($urandom);
          it.delete_mark  = ($urandom_range(0, 2) == 0);
          it.squeeze_mark = 1'($urandom);
        end else begin
          it.mode = btds_pkg::MODE_DATA;
          if ($urandom_range(0, 3) == 0) begin
            it.symbol = prev_sym;
          end else if ($urandom_range(0, 6) == 0) begin
            it.symbol = 8'($urandom);
          end else begin
            it.symbol = alpha[$urandom_range(0, 5)];
          end
          it.map_to       = 8'($urandom);
          it.delete_mark  = 1'($urandom);
          it.squeeze_mark = 1'($urandom);
          prev_sym        = it.symbol;
        end
        pending_items.insert(pending_items.size(), it);
      end

      // Halfway through one phase the sender stops until all results are in.
      if (ph == 2) begin
        while (pending_items.size() > 70) @(negedge clk_i);
        @(posedge clk_i);
        hold_sender <= 1'b1;
        @(negedge clk_i);
        while (expected_bytes.size() != 0) @(negedge clk_i);
        @(posedge clk_i);
        hold_sender <= 1'b0;
        @(negedge clk_i);
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("PASS byte_translate_delete_squeeze");
    end else begin
      $display("FAIL byte_translate_delete_squeeze");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/btds_pkg.sv
rtl/btds_if.sv
rtl/btds_fifo.sv
rtl/btds_front.sv
rtl/btds_back.sv
rtl/byte_translate_delete_squeeze.sv
rtl/btds_checker.sv
tb/sv/byte_translate_delete_squeeze_test.sv
